### src/cpr_pkg.sv
`timescale 1ns / 1ps

package cpr_pkg;

    // Table geometry
    localparam int FRAME_COUNT = 16;
    localparam int PAGE_W      = 16;
    localparam int IDX_W       = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int CNT_W       = IDX_W + 1;

    // Port field widths
    localparam int PAGE_IN_W   = 16;
    localparam int CFG_W       = 5;
    localparam int FRAME_OUT_W = 4;
    localparam int FAULT_W     = 16;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 24;
    localparam logic [CFG_W-1:0] FRAMES_RESET = 5'd4;

    // Microcode addresses
    localparam int UA_W = 3;
    localparam logic [UA_W-1:0] UA_IDLE   = 3'd0;
    localparam logic [UA_W-1:0] UA_SEARCH = 3'd1;
    localparam logic [UA_W-1:0] UA_DECIDE = 3'd2;
    localparam logic [UA_W-1:0] UA_FAULT  = 3'd3;
    localparam logic [UA_W-1:0] UA_SWEEP  = 3'd4;
    localparam logic [UA_W-1:0] UA_EMIT   = 3'd5;

    // Datapath operations
    localparam logic [2:0] OP_NOP    = 3'd0;
    localparam logic [2:0] OP_LOAD   = 3'd1;
    localparam logic [2:0] OP_SEARCH = 3'd2;
    localparam logic [2:0] OP_FAULT  = 3'd3;
    localparam logic [2:0] OP_SWEEP  = 3'd4;
    localparam logic [2:0] OP_EMIT   = 3'd5;

    // Jump conditions
    localparam logic [2:0] COND_ALWAYS   = 3'd0;
    localparam logic [2:0] COND_ACCEPT   = 3'd1;
    localparam logic [2:0] COND_SRCH_END = 3'd2;
    localparam logic [2:0] COND_HIT      = 3'd3;
    localparam logic [2:0] COND_REF_CLR  = 3'd4;
    localparam logic [2:0] COND_OUT_FREE = 3'd5;

    // One control word: op for the datapath, jump if cond, else stay or step on
    typedef struct packed {
        logic [2:0]      op;
        logic [2:0]      cond;
        logic [UA_W-1:0] target;
        logic            stay;
    } uword_t;

    // Status flags back to the sequencer
    typedef struct packed {
        logic accept;
        logic srch_end;
        logic hit;
        logic ref_clr;
        logic out_free;
    } dp_stat_t;

    // Control store
    function automatic uword_t ucode_rom(input logic [UA_W-1:0] ua);
        uword_t w;
        case (ua)
            UA_IDLE:   w = '{op: OP_LOAD,   cond: COND_ACCEPT,   target: UA_SEARCH, stay: 1'b1};
            UA_SEARCH: w = '{op: OP_SEARCH, cond: COND_SRCH_END, target: UA_DECIDE, stay: 1'b1};
            UA_DECIDE: w = '{op: OP_NOP,    cond: COND_HIT,      target: UA_EMIT,   stay: 1'b0};
            UA_FAULT:  w = '{op: OP_FAULT,  cond: COND_ALWAYS,   target: UA_SWEEP,  stay: 1'b0};
            UA_SWEEP:  w = '{op: OP_SWEEP,  cond: COND_REF_CLR,  target: UA_EMIT,   stay: 1'b1};
            UA_EMIT:   w = '{op: OP_EMIT,   cond: COND_OUT_FREE, target: UA_IDLE,   stay: 1'b1};
            default:   w = '{op: OP_NOP,    cond: COND_ALWAYS,   target: UA_IDLE,   stay: 1'b0};
        endcase
        return w;
    endfunction

endpackage

### src/cpr_useq.sv
`timescale 1ns / 1ps

module cpr_useq
(
    input  logic              clk,
    input  logic              rst_n,
    input  cpr_pkg::dp_stat_t stat,
    output cpr_pkg::uword_t   uword
);

    logic [cpr_pkg::UA_W-1:0] upc_reg;
    logic [cpr_pkg::UA_W-1:0] upc_next;
    logic                     cond_true;

    assign uword = cpr_pkg::ucode_rom(upc_reg);

    // Condition select
    always_comb
    begin
        case (uword.cond)
            cpr_pkg::COND_ALWAYS:   cond_true = 1'b1;
            cpr_pkg::COND_ACCEPT:   cond_true = stat.accept;
            cpr_pkg::COND_SRCH_END: cond_true = stat.srch_end;
            cpr_pkg::COND_HIT:      cond_true = stat.hit;
            cpr_pkg::COND_REF_CLR:  cond_true = stat.ref_clr;
            cpr_pkg::COND_OUT_FREE: cond_true = stat.out_free;
            default:                cond_true = 1'b0;
        endcase
    end

    // Next step: jump, hold, or fall through
    always_comb
    begin
        if (cond_true)
            upc_next = uword.target;
        else if (uword.stay)
            upc_next = upc_reg;
        else
            upc_next = upc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            upc_reg <= cpr_pkg::UA_IDLE;
        else
            upc_reg <= upc_next;
    end

endmodule

### src/cpr_datapath.sv
`timescale 1ns / 1ps

module cpr_datapath
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  cpr_pkg::uword_t                 uword,
    output cpr_pkg::dp_stat_t               stat,
    input  logic                            cfg_we,
    input  logic [cpr_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                            in_valid,
    input  logic [cpr_pkg::PAGE_IN_W-1:0]   in_page,
    input  logic                            in_eos,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            out_hit,
    output logic [cpr_pkg::FRAME_OUT_W-1:0] out_frame,
    output logic [cpr_pkg::FAULT_W-1:0]     out_faults
);

    localparam int FC = cpr_pkg::FRAME_COUNT;
    localparam int IW = cpr_pkg::IDX_W;
    localparam int CW = cpr_pkg::CNT_W;
    localparam int PW = cpr_pkg::PAGE_W;

    // Page store, undefined until written
    logic [PW-1:0] page_mem [FC];

    logic [cpr_pkg::CFG_W-1:0]       frames_reg;
    logic [FC-1:0]                   valid_reg, valid_next;
    logic [FC-1:0]                   refd_reg, refd_next;
    logic [IW-1:0]                   hand_reg, hand_next;
    logic [IW-1:0]                   idx_reg, idx_next;
    logic [IW-1:0]                   slot_reg, slot_next;
    logic [PW-1:0]                   pg_reg, pg_next;
    logic                            eos_reg, eos_next;
    logic                            hit_reg, hit_next;
    logic [cpr_pkg::FAULT_W-1:0]     faults_reg, faults_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            out_hit_reg, out_hit_next;
    logic [cpr_pkg::FRAME_OUT_W-1:0] out_frame_reg, out_frame_next;
    logic [cpr_pkg::FAULT_W-1:0]     out_faults_reg, out_faults_next;

    logic [CW-1:0] cnt;
    logic [IW-1:0] hand_wrap;
    logic          match;
    logic          last;
    logic          accept;
    logic          out_free;
    logic          mem_we;

    // Effective frame count, clamped to 1..FRAME_COUNT
    always_comb
    begin
        if (frames_reg == '0)
            cnt = CW'(1);
        else if (int'(frames_reg) > FC)
            cnt = CW'(FC);
        else
            cnt = CW'(frames_reg);
    end

    assign hand_wrap = (({1'b0, hand_reg} + 1'b1) == cnt) ? '0 : hand_reg + 1'b1;
    assign match     = valid_reg[idx_reg] && (page_mem[idx_reg] == pg_reg);
    assign last      = ({1'b0, idx_reg} == (cnt - 1'b1));
    assign accept    = in_valid && (uword.op == cpr_pkg::OP_LOAD);
    assign out_free  = !out_valid_reg || out_ready;

    assign stat.accept   = accept;
    assign stat.srch_end = match || last;
    assign stat.hit      = hit_reg;
    assign stat.ref_clr  = !refd_reg[hand_reg];
    assign stat.out_free = out_free;

    // Operation decode
    always_comb
    begin
        valid_next      = valid_reg;
        refd_next       = refd_reg;
        hand_next       = hand_reg;
        idx_next        = idx_reg;
        slot_next       = slot_reg;
        pg_next         = pg_reg;
        eos_next        = eos_reg;
        hit_next        = hit_reg;
        faults_next     = faults_reg;
        out_hit_next    = out_hit_reg;
        out_frame_next  = out_frame_reg;
        out_faults_next = out_faults_reg;
        out_valid_next  = out_ready ? 1'b0 : out_valid_reg;
        mem_we          = 1'b0;
        case (uword.op)
            cpr_pkg::OP_LOAD:
            begin
                if (accept)
                begin
                    pg_next  = in_page[PW-1:0];
                    eos_next = in_eos;
                    hit_next = 1'b0;
                    idx_next = '0;
                    if ({1'b0, hand_reg} >= cnt)
                        hand_next = '0;
                end
            end
            cpr_pkg::OP_SEARCH:
            begin
                if (match)
                begin
                    hit_next           = 1'b1;
                    slot_next          = idx_reg;
                    refd_next[idx_reg] = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            cpr_pkg::OP_FAULT:
            begin
                if (faults_reg != '1)
                    faults_next = faults_reg + 1'b1;
            end
            cpr_pkg::OP_SWEEP:
            begin
                // second chance: clear and pass, or take the frame
                hand_next = hand_wrap;
                if (refd_reg[hand_reg])
                begin
                    refd_next[hand_reg] = 1'b0;
                end
                else
                begin
                    mem_we               = 1'b1;
                    valid_next[hand_reg] = 1'b1;
                    refd_next[hand_reg]  = 1'b1;
                    slot_next            = hand_reg;
                end
            end
            cpr_pkg::OP_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_hit_next    = hit_reg;
                    out_frame_next  = cpr_pkg::FRAME_OUT_W'(slot_reg);
                    out_faults_next = faults_reg;
                    if (eos_reg)
                    begin
                        valid_next  = '0;
                        refd_next   = '0;
                        hand_next   = '0;
                        faults_next = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Page store write
    always_ff @(posedge clk)
    begin
        if (mem_we)
            page_mem[hand_reg] <= pg_reg;
    end

    // Control and table state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg    <= cpr_pkg::FRAMES_RESET;
            valid_reg     <= '0;
            refd_reg      <= '0;
            hand_reg      <= '0;
            faults_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                frames_reg <= cfg_wdata;
            valid_reg     <= valid_next;
            refd_reg      <= refd_next;
            hand_reg      <= hand_next;
            faults_reg    <= faults_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and result words
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        slot_reg       <= slot_next;
        pg_reg         <= pg_next;
        eos_reg        <= eos_next;
        hit_reg        <= hit_next;
        out_hit_reg    <= out_hit_next;
        out_frame_reg  <= out_frame_next;
        out_faults_reg <= out_faults_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_hit    = out_hit_reg;
    assign out_frame  = out_frame_reg;
    assign out_faults = out_faults_reg;

endmodule

### src/clock_page_replacement.sv
`timescale 1ns / 1ps

// Channel     Dir  Handshake          Payload
// s_axis      in   s_tvalid/s_tready  tdata: page_number; tuser: end_of_sequence
// m_axis      out  m_tvalid/m_tready  tdata: frame_index, fault_count; tuser: hit
// cfg         in   cfg_we             cfg_wdata: frames_in_use
//
// One word at a time. A hit at frame k searches frames 0..k, then decodes
// and issues; a miss searches all n frames in use, decodes, counts a fault,
// sweeps the clock hand until it takes a frame, and issues. The microcode
// loop visits one frame per cycle. No clearing pass after reset. The result
// sits in an output register, so the next word is taken while the last
// result waits for m_tready.

module clock_page_replacement
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cpr_pkg::S_TDATA_W-1:0]   s_tdata,   // [15:0] page_number
    input  logic [0:0]                      s_tuser,   // [0] end_of_sequence
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cpr_pkg::M_TDATA_W-1:0]   m_tdata,   // [3:0] frame_index, [19:4] fault_count
    output logic [0:0]                      m_tuser,   // [0] hit
    input  logic                            cfg_we,
    input  logic [cpr_pkg::CFG_W-1:0]       cfg_wdata
);

    cpr_pkg::uword_t                 uword;
    cpr_pkg::dp_stat_t               stat;
    logic                            out_hit;
    logic [cpr_pkg::FRAME_OUT_W-1:0] out_frame;
    logic [cpr_pkg::FAULT_W-1:0]     out_faults;

    // Microcode sequencer
    cpr_useq u_useq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .uword (uword)
    );

    // Frame table and result datapath
    cpr_datapath u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .uword      (uword),
        .stat       (stat),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_tvalid),
        .in_page    (s_tdata),
        .in_eos     (s_tuser[0]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_hit    (out_hit),
        .out_frame  (out_frame),
        .out_faults (out_faults)
    );

    assign s_tready = (uword.op == cpr_pkg::OP_LOAD);
    assign m_tuser  = out_hit;
    assign m_tdata  = {
        {(cpr_pkg::M_TDATA_W - cpr_pkg::FAULT_W - cpr_pkg::FRAME_OUT_W){1'b0}},
        out_faults,
        out_frame
    };

endmodule
